>>> sv/vscsm_pkg.sv
// Package for the voxel sign change surface marker: grid limits, field widths,
// register indexes and the stored voxel entry type. Depends on nothing.
package vscsm_pkg;

  localparam int unsigned MAX_X      = 128;
  localparam int unsigned MAX_Y      = 128;
  localparam int unsigned MAX_Z      = 128;
  localparam int unsigned DIST_WIDTH = 16;

  localparam int unsigned X_BITS = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int unsigned Y_BITS = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int unsigned Z_BITS = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

  localparam int unsigned PLANE_DEPTH = MAX_X * MAX_Y;
  localparam int unsigned ADDR_BITS   = $clog2(PLANE_DEPTH);

  localparam int unsigned SIZE_WIDTH = 8;
  localparam int unsigned SIZE_RESET = 128;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_HOLLOW_MODE = 2'd0,
    REG_GRID_SIZE_X = 2'd1,
    REG_GRID_SIZE_Y = 2'd2,
    REG_GRID_SIZE_Z = 2'd3
  } cfg_reg_t;

  // One voxel as held in the plane store.
  typedef struct packed {
    logic                  updated;
    logic [DIST_WIDTH-1:0] dval;
  } entry_t;

  localparam int unsigned ENTRY_WIDTH = $bits(entry_t);

  // Last usable position on an axis: a size of zero acts as one, a size
  // above the axis maximum acts as that maximum.
  function automatic int unsigned last_index(input logic [SIZE_WIDTH-1:0] size,
                                             input int unsigned max_size);
    int unsigned s;
    s = int'(size);
    if (s == 0) begin
      return 0;
    end else if (s > max_size) begin
      return max_size - 1;
    end
    return s - 1;
  endfunction

endpackage

>>> sv/vscsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the contents before a write in the same cycle. No dependencies.
module vscsm_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/voxel_sign_change_surface_marker_core.sv
// Top level of the voxel sign change surface marker.
// Uses vscsm_pkg for constants and types and vscsm_ram for the plane store.
//
// Usage:
//   Voxels arrive on the voxel channel (voxel_valid / voxel_stall) in raster
//   order, x fastest, then y, then z, one transfer per voxel carrying a signed
//   Q8.8 distance and an updated bit. Each voxel yields exactly one transfer on
//   the result channel (result_valid / result_stall) with surface_hit, emit and
//   last_voxel, in the same order.
//   Each voxel passes through the input stage and then the result register.
//   Throughput: one voxel per cycle while the receiver does not stall; the
//   plane store is two RAM copies (one per neighbour read) written once per
//   voxel, so the RAM ports set that figure.
//   When the receiver stalls, the result register holds and the input stage
//   still takes one more voxel; beyond that voxel_stall rises.
//   Configuration (cfg_valid / cfg_ready, always ready) sets hollow_mode and
//   the grid sizes; write it only while no voxel is in flight.
//   Reset (synchronous, rst high) empties both stages, returns the position
//   counters to the grid origin and loads the register defaults. The plane
//   store has no reset; every entry is written before it is read within a
//   grid, so no clearing pass is needed.
module voxel_sign_change_surface_marker_core (
  input  logic                                             clk,
  input  logic                                             rst,
  // voxel channel
  input  logic                                             voxel_valid,
  output logic                                             voxel_stall,
  input  logic signed [vscsm_pkg::DIST_WIDTH-1:0]          distance,
  input  logic                                             updated,
  // result channel
  output logic                                             result_valid,
  input  logic                                             result_stall,
  output logic                                             surface_hit,
  output logic                                             emit,
  output logic                                             last_voxel,
  // configuration write channel
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [vscsm_pkg::CFG_INDEX_WIDTH-1:0]            cfg_index,
  input  logic [vscsm_pkg::SIZE_WIDTH-1:0]                 cfg_data
);

  localparam int unsigned XB = vscsm_pkg::X_BITS;
  localparam int unsigned YB = vscsm_pkg::Y_BITS;
  localparam int unsigned ZB = vscsm_pkg::Z_BITS;
  localparam int unsigned AB = vscsm_pkg::ADDR_BITS;
  localparam int unsigned DW = vscsm_pkg::DIST_WIDTH;

  localparam logic [XB-1:0] LAST_X_RESET = XB'(vscsm_pkg::last_index(
      vscsm_pkg::SIZE_WIDTH'(vscsm_pkg::SIZE_RESET), vscsm_pkg::MAX_X));
  localparam logic [YB-1:0] LAST_Y_RESET = YB'(vscsm_pkg::last_index(
      vscsm_pkg::SIZE_WIDTH'(vscsm_pkg::SIZE_RESET), vscsm_pkg::MAX_Y));
  localparam logic [ZB-1:0] LAST_Z_RESET = ZB'(vscsm_pkg::last_index(
      vscsm_pkg::SIZE_WIDTH'(vscsm_pkg::SIZE_RESET), vscsm_pkg::MAX_Z));

  // Configuration, sizes kept as the last index on each axis.
  logic          hollow_mode;
  logic [XB-1:0] last_x;
  logic [YB-1:0] last_y;
  logic [ZB-1:0] last_z;

  // Position of the next voxel.
  logic [XB-1:0] count_x;
  logic [YB-1:0] count_y;
  logic [ZB-1:0] count_z;

  // Input stage.
  logic                s1_valid;
  vscsm_pkg::entry_t   s1_cur;
  vscsm_pkg::entry_t   s1_left;
  logic                s1_has_x;
  logic                s1_has_y;
  logic                s1_has_z;
  logic                s1_last;

  // Plane store read data: row above and previous plane.
  vscsm_pkg::entry_t   up_entry;
  vscsm_pkg::entry_t   back_entry;

  logic                voxel_accept;
  logic                s1_adv;
  logic                end_x;
  logic                end_y;
  logic                end_z;
  logic [AB-1:0]       idx;
  logic [AB-1:0]       up_addr;
  vscsm_pkg::entry_t   in_entry;

  logic                surf_next;
  logic                emit_next;
  logic                cur_zero;
  logic                cur_neg;

  assign cfg_ready = 1'b1;

  // Advance the input stage whenever the result register is free or drains.
  assign s1_adv       = !result_valid || !result_stall;
  assign voxel_stall  = s1_valid && !s1_adv;
  assign voxel_accept = voxel_valid && !voxel_stall;

  assign end_x = (count_x >= last_x);
  assign end_y = (count_y >= last_y);
  assign end_z = (count_z >= last_z);

  assign idx     = AB'(int'(count_y) * vscsm_pkg::MAX_X + int'(count_x));
  // Meaningless on the first row; the y test is gated there.
  assign up_addr = idx - AB'(vscsm_pkg::MAX_X);

  assign in_entry.updated = updated;
  assign in_entry.dval    = distance;

  // Both copies take the same write; each serves one neighbour read.
  // The read at the write address returns the previous plane's voxel.
  vscsm_ram #(
    .WIDTH (vscsm_pkg::ENTRY_WIDTH),
    .DEPTH (vscsm_pkg::PLANE_DEPTH)
  ) u_ram_up (
    .clk   (clk),
    .we    (voxel_accept),
    .waddr (idx),
    .wdata (in_entry),
    .re    (voxel_accept),
    .raddr (up_addr),
    .rdata (up_entry)
  );

  vscsm_ram #(
    .WIDTH (vscsm_pkg::ENTRY_WIDTH),
    .DEPTH (vscsm_pkg::PLANE_DEPTH)
  ) u_ram_back (
    .clk   (clk),
    .we    (voxel_accept),
    .waddr (idx),
    .wdata (in_entry),
    .re    (voxel_accept),
    .raddr (idx),
    .rdata (back_entry)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hollow_mode <= 1'b0;
      last_x      <= LAST_X_RESET;
      last_y      <= LAST_Y_RESET;
      last_z      <= LAST_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vscsm_pkg::REG_HOLLOW_MODE: hollow_mode <= cfg_data[0];
        vscsm_pkg::REG_GRID_SIZE_X:
          last_x <= XB'(vscsm_pkg::last_index(cfg_data, vscsm_pkg::MAX_X));
        vscsm_pkg::REG_GRID_SIZE_Y:
          last_y <= YB'(vscsm_pkg::last_index(cfg_data, vscsm_pkg::MAX_Y));
        vscsm_pkg::REG_GRID_SIZE_Z:
          last_z <= ZB'(vscsm_pkg::last_index(cfg_data, vscsm_pkg::MAX_Z));
        default: ;
      endcase
    end
  end

  // Raster counters: wrap an axis at its last index and carry into the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_x <= '0;
      count_y <= '0;
      count_z <= '0;
    end else if (voxel_accept) begin
      if (!end_x) begin
        count_x <= count_x + XB'(1);
      end else begin
        count_x <= '0;
        if (!end_y) begin
          count_y <= count_y + YB'(1);
        end else begin
          count_y <= '0;
          if (!end_z) begin
            count_z <= count_z + ZB'(1);
          end else begin
            count_z <= '0;
          end
        end
      end
    end
  end

  // Input stage. The x-1 neighbour is the voxel accepted just before, which
  // still sits in s1_cur at this edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (voxel_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (voxel_accept) begin
      s1_left  <= s1_cur;
      s1_cur   <= in_entry;
      s1_has_x <= (count_x != '0);
      s1_has_y <= (count_y != '0);
      s1_has_z <= (count_z != '0);
      s1_last  <= end_x && end_y && end_z;
    end
  end

  // A neighbour marks the voxel when both are updated and either the voxel
  // sits exactly at zero or the two signs are strictly opposite.
  function automatic logic marks(input vscsm_pkg::entry_t cur,
                                 input vscsm_pkg::entry_t nb);
    logic c_zero;
    logic n_zero;
    c_zero = (cur.dval == '0);
    n_zero = (nb.dval == '0);
    return cur.updated && nb.updated &&
           (c_zero || (!n_zero && (cur.dval[DW-1] != nb.dval[DW-1])));
  endfunction

  assign cur_zero = (s1_cur.dval == '0);
  assign cur_neg  = s1_cur.dval[DW-1];

  always_comb begin
    surf_next = (s1_has_x && marks(s1_cur, s1_left)) ||
                (s1_has_y && marks(s1_cur, up_entry)) ||
                (s1_has_z && marks(s1_cur, back_entry));
    if (hollow_mode) begin
      emit_next = surf_next;
    end else begin
      emit_next = s1_cur.updated && (cur_neg || cur_zero);
    end
  end

  // Result register: load on advance, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      surface_hit <= surf_next;
      emit        <= emit_next;
      last_voxel  <= s1_last;
    end
  end

  // The final voxel of the grid sends all counters back to the origin.
  a_wrap_to_origin: assert property (@(posedge clk) disable iff (rst)
    voxel_accept && end_x && end_y && end_z |=>
      (count_x == '0) && (count_y == '0) && (count_z == '0))
    else $error("counters did not wrap after the final voxel");

  // An item held in the input stage is never dropped.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input stage lost an item while blocked");

  // In hollow mode a shown result emits exactly the surface voxels.
  a_hollow_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid && hollow_mode && $past(hollow_mode) |-> emit == surface_hit)
    else $error("hollow mode emit differs from surface_hit");

endmodule
